// ===== hw/rtl/pvds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvds_pkg
// Shared types, constants and helpers for the voxel density sampler.
// ----------------------------------------------------------------------------
package pvds_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int CELL_SHIFT_DEF = 5;

  localparam logic [63:0] K_GOLD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] K_MIX1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] K_MIX2 = 64'h94d049bb133111eb;
  localparam logic [63:0] K_MIX3 = 64'h632be59bd9b4e019;

  localparam int          WEIGHT_A  = 42598;
  localparam int          WEIGHT_B  = 22938;
  localparam logic [31:0] SEED_STEP = 32'd17;
  localparam int          AMP_FRAC  = 8;
  localparam int          BLEND_FRAC = 31;

  localparam logic [30:0] RADIUS_RST = 31'd256000;
  localparam logic [15:0] AMP_RST    = 16'd2048;
  localparam logic [31:0] SEED_RST   = 32'd0;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_AMP    = 2'd1,
    REG_SEED   = 2'd2
  } reg_idx_e;

  // partial products of a 64x64 multiply kept modulo 2^64
  typedef struct packed {
    logic [63:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.p0 = 64'(a[31:0]) * 64'(b[31:0]);
    r.p1 = 32'(a[31:0] * b[63:32]);
    r.p2 = 32'(a[63:32] * b[31:0]);
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t pp);
    logic [31:0] hi;
    hi = pp.p1 + pp.p2;
    return pp.p0 + {hi, 32'd0};
  endfunction

endpackage

// ===== hw/rtl/planetoid_voxel_density_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planetoid_voxel_density_sampler_unit
// Hash-noise sphere density: two cell hashes blended into terrain height,
// minus the integer length of the position.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the 32-stage square root pipeline sets
// the depth, and the whole pipeline holds while the result is not taken.
// Reset: registers return to radius 256000, amplitude 2048, seed 0; the
// pipeline empties.
module planetoid_voxel_density_sampler_unit #(
  parameter int FRAC_BITS  = pvds_pkg::FRAC_BITS_DEF,
  parameter int CELL_SHIFT = pvds_pkg::CELL_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] density_o,
  output logic               height_band_o,
  output logic [1:0]         biome_o
);
  import pvds_pkg::*;

  localparam int CS    = FRAC_BITS + CELL_SHIFT;
  localparam int TS    = BLEND_FRAC + AMP_FRAC - FRAC_BITS;
  localparam int NST   = 36;
  localparam int NDLY  = 23;
  localparam logic signed [51:0] FOUR = 52'sd4 <<< (BLEND_FRAC + AMP_FRAC);
  localparam logic signed [51:0] RND  = 52'sd1 <<< (TS - 1);

  typedef struct packed {
    logic signed [51:0] terrain;
    logic [1:0]         biome;
  } tb_t;

  // configuration
  logic [30:0] radius_q;
  logic [15:0] amp_q;
  logic [31:0] seed_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      amp_q    <= AMP_RST;
      seed_q   <= SEED_RST;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_RADIUS: radius_q <= pwdata[30:0];
        REG_AMP:    amp_q    <= pwdata[15:0];
        REG_SEED:   seed_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_RADIUS: prdata = {1'b0, radius_q};
      REG_AMP:    prdata = {16'd0, amp_q};
      REG_SEED:   prdata = seed_q;
      default:    prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 0: capture
  logic signed [31:0] x_q, y_q, z_q;
  logic [63:0]        cc_q [3];
  logic [31:0]        sd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      z_q      <= pos_z_i;
      cc_q[0]  <= 64'(pos_x_i >>> CS);
      cc_q[1]  <= 64'(pos_y_i >>> CS);
      cc_q[2]  <= 64'(pos_z_i >>> CS);
      sd_q     <= seed_q;
    end
  end

  // hash pipelines, stages 1 to 7
  logic signed [16:0] n_q [2];

  for (genvar g = 0; g < 2; g++) begin : g_hash
    logic [63:0] kc [3];
    pp_t         ppc_q [3];
    logic [63:0] hs_q, hb_q;
    logic [63:0] m_q [3];
    logic [63:0] h3_q, h5_q, hx, t5, t7;
    pp_t         pp4_q, pp6_q;
    logic [31:0] sdg;

    assign kc[0] = K_MIX1;
    assign kc[1] = K_MIX2;
    assign kc[2] = K_MIX3;
    assign sdg = (g == 1) ? sd_q + SEED_STEP : sd_q;
    assign hx = hb_q ^ m_q[0] ^ m_q[1] ^ m_q[2];
    assign t5 = pp_sum(pp4_q);
    assign t7 = pp_sum(pp6_q);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int j = 0; j < 3; j++) begin
          ppc_q[j] <= pp_mul((g == 1) ? (cc_q[j] << 1) : cc_q[j], kc[j]);
          m_q[j]   <= pp_sum(ppc_q[j]);
        end
        hs_q  <= {32'd0, sdg} + K_GOLD;
        hb_q  <= hs_q;
        h3_q  <= hx ^ (hx >> 30);
        pp4_q <= pp_mul(h3_q, K_MIX1);
        h5_q  <= t5 ^ (t5 >> 27);
        pp6_q <= pp_mul(h5_q, K_MIX2);
        n_q[g] <= $signed({1'b0, t7[15:0] ^ t7[46:31]}) - 17'sd32768;
      end
    end
  end

  // blend and scale, stages 8 to 11
  logic signed [34:0] wa_q, wb_q, blend_q;
  logic signed [51:0] p_q, pr;
  tb_t                tb_q;
  tb_t                dl_q [NDLY];

  assign pr = p_q + RND;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q    <= 35'(n_q[0]) * $signed(35'(WEIGHT_A));
      wb_q    <= 35'(n_q[1]) * $signed(35'(WEIGHT_B));
      blend_q <= wa_q + wb_q;
      p_q     <= 52'(blend_q) * $signed({36'd0, amp_q});
      tb_q.terrain <= pr >>> TS;
      if (p_q > FOUR) begin
        tb_q.biome <= 2'd2;
      end else if (p_q < -FOUR) begin
        tb_q.biome <= 2'd1;
      end else begin
        tb_q.biome <= 2'd0;
      end
      dl_q[0] <= tb_q;
      for (int k = 1; k < NDLY; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  // length: squares, sum, 32 square root steps (stages 1 to 34)
  logic signed [63:0] sx_q, sy_q, sz_q;
  logic [63:0]        sq_q;
  logic [63:0]        rem_q [32];
  logic [63:0]        res_q [32];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= x_q * x_q;
      sy_q <= y_q * y_q;
      sz_q <= z_q * z_q;
      sq_q <= 64'(sx_q) + 64'(sy_q) + 64'(sz_q);
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (2 * (31 - k));
    logic [63:0] rin, sin, trial;
    if (k == 0) begin : g_first
      assign rin = sq_q;
      assign sin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign sin = res_q[k-1];
    end
    assign trial = sin + BITV;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rin >= trial) begin
          rem_q[k] <= rin - trial;
          res_q[k] <= (sin >> 1) + BITV;
        end else begin
          rem_q[k] <= rin;
          res_q[k] <= sin >> 1;
        end
      end
    end
  end

  // stage 35: result register
  logic signed [53:0] dsum;
  logic [31:0]        dlen;

  assign dlen = res_q[31][31:0];
  assign dsum = $signed({23'd0, radius_q}) + 54'(dl_q[NDLY-1].terrain)
              - $signed({22'd0, dlen});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dsum > 54'sd2147483647) begin
        density_o <= 32'sh7fffffff;
      end else if (dsum < -54'sd2147483648) begin
        density_o <= 32'sh80000000;
      end else begin
        density_o <= dsum[31:0];
      end
      height_band_o <= !(dlen < {1'b0, radius_q});
      biome_o       <= dl_q[NDLY-1].biome;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("pipeline stalled while output empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0]) else $error("accepted request lost");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q)) else $error("pipeline moved during stall");

endmodule

// ===== tb/tb_planetoid_voxel_density_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planetoid_voxel_density_sampler_unit
// Streams voxel positions through the density sampler under random stalls on
// both sides and under several register settings, and checks every density,
// height band and biome against a cycle-free model of the hash-noise sphere.
// ----------------------------------------------------------------------------
module tb_planetoid_voxel_density_sampler_unit;
  import pvds_pkg::*;

  localparam int WDOG_MAX  = 20000;
  localparam int LATENCY   = 36;

  typedef struct {
    logic signed [31:0] dens;
    logic               band;
    logic [1:0]         biome;
  } sample_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 known;
    sample_t            res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] density_o;
  logic height_band_o;
  logic [1:0] biome_o;

  logic [30:0] radius_q = RADIUS_RST;
  logic [15:0] amp_q = AMP_RST;
  logic [31:0] seed_q = SEED_RST;

  sample_t expected_q[$];
  int errors = 0;
  int wdog = 0;
  bit rx_hold = 1'b0;
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  planetoid_voxel_density_sampler_unit u_dut (.*);

  function automatic logic signed [63:0] cell_noise(input logic signed [63:0] cx,
      input logic signed [63:0] cy, input logic signed [63:0] cz, input logic [31:0] seed);
    logic [63:0] h;
    h = 64'(seed) + K_GOLD;
    h ^= cx * K_MIX1;
    h ^= cy * K_MIX2;
    h ^= cz * K_MIX3;
    h ^= h >> 30;
    h *= K_MIX1;
    h ^= h >> 27;
    h *= K_MIX2;
    h ^= h >> 31;
    return $signed({48'd0, h[15:0]}) - 64'sd32768;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic sample_t density_of(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz);
    logic signed [63:0] x, y, z, cx, cy, cz, n1, n2, blend, p, terr, four, dlen, dens;
    logic [63:0] sq;
    sample_t r;
    x = px; y = py; z = pz;
    cx = x >>> 13; cy = y >>> 13; cz = z >>> 13;
    n1 = cell_noise(cx, cy, cz, seed_q);
    n2 = cell_noise(cx * 2, cy * 2, cz * 2, seed_q + SEED_STEP);
    blend = n1 * WEIGHT_A + n2 * WEIGHT_B;
    p = blend * $signed({48'd0, amp_q});
    terr = (p + (64'sd1 <<< 30)) >>> 31;
    four = 64'sd4 <<< (BLEND_FRAC + AMP_FRAC);
    sq = x * x + y * y + z * z;
    dlen = $signed(int_sqrt(sq));
    dens = $signed({33'd0, radius_q}) + terr - dlen;
    if (dens > 64'sd2147483647) dens = 64'sd2147483647;
    if (dens < -64'sd2147483648) dens = -64'sd2147483648;
    r.dens = dens[31:0];
    r.band = (dlen < $signed({33'd0, radius_q})) ? 1'b0 : 1'b1;
    r.biome = (p > four) ? 2'd2 : (p < -four) ? 2'd1 : 2'd0;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: radius_q = val[30:0];
      REG_AMP:    amp_q = val[15:0];
      default:    seed_q = val;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic send_pos(input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z, input bit known, input sample_t res, input int gap);
    sample_t e;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1; pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    e = known ? res : density_of(x, y, z);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q = {expected_q, e};
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_pos(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 400000)) - 200000;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic random_phase(input int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(0, 9) < 6) ? 1 : ($urandom_range(0, 9) == 0 ? 2 : 0);
      send_pos(rand_pos(m), rand_pos(m), rand_pos(m), 1'b0, '{0, 0, 0}, gap_len());
    end
  endtask

  initial begin
    stim_row_t rows [10];
    sample_t nul;
    nul = '{0, 0, 0};
    // origin at reset: distance 0, so band 0; terrain small relative to radius
    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, nul},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, nul},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, nul},
      '{32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b0, nul},
      '{-32'sd1, -32'sd1, -32'sd1, 1'b0, nul},
      '{-32'sd8192, 32'sd8191, 32'sd8192, 1'b0, nul},
      '{32'sd256000, 32'sd0, 32'sd0, 1'b0, nul},
      '{32'sd0, -32'sd256000, 32'sd0, 1'b0, nul},
      '{32'sd0, 32'sd0, 32'sd255999, 1'b0, nul},
      '{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 1'b0, nul}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i])
      send_pos(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res, gap_len());
    drain();

    // zero amplitude and zero radius: density is minus the distance, band 1
    reg_write(REG_RADIUS, 32'd0);
    reg_write(REG_AMP, 32'd0);
    reg_write(REG_SEED, 32'hffffffff);
    send_pos(32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 1'b1, 2'd0}, 0);
    send_pos(32'sd3, 32'sd4, 32'sd0, 1'b1, '{-32'sd5, 1'b1, 2'd0}, 0);
    send_pos(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1,
             '{32'sh80000000, 1'b1, 2'd0}, 0);
    drain();

    // maximum radius and amplitude, upper bits of the register written ignored
    reg_write(REG_RADIUS, 32'hffffffff);
    reg_write(REG_AMP, 32'hffffffff);
    send_pos(32'sd0, 32'sd0, 32'sd0, 1'b0, nul, 0);
    send_pos(32'sd1000, 32'sd0, 32'sd0, 1'b0, nul, 0);
    random_phase(300);
    drain();

    // receiver stalls long while requests keep coming
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      random_phase(100);
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_RADIUS, $urandom());
      reg_write(REG_AMP, $urandom());
      reg_write(REG_SEED, $urandom());
      random_phase(225);
      drain();
    end

    reg_write(REG_RADIUS, 32'd256000);
    reg_write(REG_AMP, 32'd2048);
    reg_write(REG_SEED, 32'd0);
    random_phase(100);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  always @(negedge clk_i) begin
    int g;
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result density %0d", $time, density_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (density_o !== e.dens) begin
            $display("%0t: density expected %0d actual %0d", $time, e.dens, density_o);
            errors++;
          end
          if (height_band_o !== e.band) begin
            $display("%0t: height_band expected %0d actual %0d", $time, e.band,
                     height_band_o);
            errors++;
          end
          if (biome_o !== e.biome) begin
            $display("%0t: biome expected %0d actual %0d", $time, e.biome, biome_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0 && wdog < WDOG_MAX) @(posedge clk_i);
    if (wdog >= WDOG_MAX) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (errors == 0 && expected_q.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

  initial begin
    wait (rst_ni);
    wait (wdog >= WDOG_MAX);
    $display("%0t: watchdog expired", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pvds_pkg.sv
hw/rtl/planetoid_voxel_density_sampler_unit.sv
tb/tb_planetoid_voxel_density_sampler_unit.sv
